/* rtl/bls_pkg.sv */
// Shared types, register indexes and constants for the Bresenham line stepper.
`timescale 1ns / 1ps

package bls_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int ADDR_BITS      = 27;
	localparam int WIN_BITS       = 11;
	localparam int BPP_BITS       = 4;
	localparam int LINE_BITS      = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_BYTES = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BPP        = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_HEIGHT = 2'd3;

	localparam logic [LINE_BITS-1:0] LINE_BYTES_RST = 16'd7680;
	localparam logic [BPP_BITS-1:0]  BPP_RST        = 4'd4;
	localparam logic [WIN_BITS-1:0]  WIN_WIDTH_RST  = 11'd1920;
	localparam logic [WIN_BITS-1:0]  WIN_HEIGHT_RST = 11'd1080;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef struct packed {
		logic [LINE_BITS-1:0] line_bytes;
		logic [BPP_BITS-1:0]  bytes_per_pixel;
		logic [WIN_BITS-1:0]  win_width;
		logic [WIN_BITS-1:0]  win_rows;
	} cfg_t;

endpackage

/* rtl/bresenham_line_pixel_stepper.sv */
// Bresenham line stepper top level: configuration registers, front, queue and back.
// Each result passes through the point queue, the address stage register and the output register.
// Throughput: one item per cycle while the queue is not full; the step loop closes on the front's error register.
// A four-entry point queue lets the front keep accepting while the output stalls.
// Reset: asynchronous, active low; clears the segment state to the single point (0,0),
// empties the queue and the back pipeline, and loads the register defaults.
`timescale 1ns / 1ps

module bresenham_line_pixel_stepper #(
	parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bls_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [bls_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic signed [COORD_BITS-1:0]         start_x,
	input  logic signed [COORD_BITS-1:0]         start_y,
	input  logic signed [COORD_BITS-1:0]         end_x,
	input  logic signed [COORD_BITS-1:0]         end_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [COORD_BITS-1:0]         pixel_x,
	output logic signed [COORD_BITS-1:0]         pixel_y,
	output logic                                 in_window,
	output logic [bls_pkg::ADDR_BITS-1:0]        byte_address,
	output logic                                 last
);
	import bls_pkg::*;

	localparam int PW = 2 * COORD_BITS + 1;

	cfg_t          cfg_q;
	logic          q_full, q_push, q_pop, q_not_empty;
	logic [PW-1:0] q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_bytes      <= LINE_BYTES_RST;
			cfg_q.bytes_per_pixel <= BPP_RST;
			cfg_q.win_width       <= WIN_WIDTH_RST;
			cfg_q.win_rows        <= WIN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_BYTES: cfg_q.line_bytes      <= cfg_data[LINE_BITS-1:0];
				REG_BPP:        cfg_q.bytes_per_pixel <= cfg_data[BPP_BITS-1:0];
				REG_WIN_WIDTH:  cfg_q.win_width       <= cfg_data[WIN_BITS-1:0];
				REG_WIN_HEIGHT: cfg_q.win_rows        <= cfg_data[WIN_BITS-1:0];
				default:        ;
			endcase
		end
	end

	bls_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_wdata)
	);

	bls_fifo #(
		.WIDTH (PW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	bls_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_not_empty),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.in_window    (in_window),
		.byte_address (byte_address),
		.last         (last)
	);

endmodule

/* rtl/bls_fifo.sv */
// Short point queue between the stepping front and the addressing back.
`timescale 1ns / 1ps

module bls_fifo #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty,
	output logic             full
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/bls_front.sv */
// Front end: takes load and step items, runs the Bresenham error state, queues points.
`timescale 1ns / 1ps

module bls_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic                         q_full,
	output logic                         push,
	output logic [2*COORD_BITS:0]        push_data
);
	import bls_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int EW = COORD_BITS + 2;

	logic signed [CB-1:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic [CB-1:0]        delta_x_q, delta_y_q;
	logic                 dir_x_neg_q, dir_y_neg_q;
	logic signed [EW-1:0] error_q;

	logic signed [CB:0]   diff_x, diff_y;
	logic [CB:0]          abs_x, abs_y;
	logic [CB-1:0]        ld_dx, ld_dy;
	logic signed [EW-1:0] ld_err;

	logic                 at_goal, take_x, take_y;
	logic signed [EW-1:0] dx_ext, dy_ext, step_err;

	logic signed [CB-1:0] nx, ny, ngx, ngy;
	logic [CB-1:0]        ndx, ndy;
	logic                 ndxn, ndyn;
	logic signed [EW-1:0] nerr;
	logic                 accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept;

	// load: absolute deltas and initial error
	always_comb begin
		diff_x = $signed({end_x[CB-1], end_x}) - $signed({start_x[CB-1], start_x});
		diff_y = $signed({end_y[CB-1], end_y}) - $signed({start_y[CB-1], start_y});
		abs_x  = diff_x[CB] ? (CB+1)'(-diff_x) : diff_x;
		abs_y  = diff_y[CB] ? (CB+1)'(-diff_y) : diff_y;
		ld_dx  = abs_x[CB-1:0];
		ld_dy  = abs_y[CB-1:0];
		if (ld_dx > ld_dy) begin
			ld_err = $signed({3'b000, ld_dx[CB-1:1]});
		end else begin
			ld_err = -$signed({3'b000, ld_dy[CB-1:1]});
		end
	end

	// step: both error tests look at the error before either update
	always_comb begin
		at_goal  = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
		dx_ext   = $signed({2'b00, delta_x_q});
		dy_ext   = $signed({2'b00, delta_y_q});
		take_x   = error_q > -dx_ext;
		take_y   = error_q < dy_ext;
		step_err = error_q - (take_x ? dy_ext : '0) + (take_y ? dx_ext : '0);
	end

	always_comb begin
		nx   = cur_x_q;
		ny   = cur_y_q;
		ngx  = goal_x_q;
		ngy  = goal_y_q;
		ndx  = delta_x_q;
		ndy  = delta_y_q;
		ndxn = dir_x_neg_q;
		ndyn = dir_y_neg_q;
		nerr = error_q;
		if (kind == KIND_LOAD) begin
			nx   = start_x;
			ny   = start_y;
			ngx  = end_x;
			ngy  = end_y;
			ndx  = ld_dx;
			ndy  = ld_dy;
			ndxn = !(start_x < end_x);
			ndyn = !(start_y < end_y);
			nerr = ld_err;
		end else if (!at_goal) begin
			nerr = step_err;
			if (take_x) begin
				nx = dir_x_neg_q ? cur_x_q - CB'(1) : cur_x_q + CB'(1);
			end
			if (take_y) begin
				ny = dir_y_neg_q ? cur_y_q - CB'(1) : cur_y_q + CB'(1);
			end
		end
	end

	assign push_data = {((nx == ngx) && (ny == ngy)), ny, nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			goal_x_q    <= '0;
			goal_y_q    <= '0;
			delta_x_q   <= '0;
			delta_y_q   <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			error_q     <= '0;
		end else if (accept) begin
			cur_x_q     <= nx;
			cur_y_q     <= ny;
			goal_x_q    <= ngx;
			goal_y_q    <= ngy;
			delta_x_q   <= ndx;
			delta_y_q   <= ndy;
			dir_x_neg_q <= ndxn;
			dir_y_neg_q <= ndyn;
			error_q     <= nerr;
		end
	end

endmodule

/* rtl/bls_back.sv */
// Back end: window test and frame-buffer address for each queued point.
`timescale 1ns / 1ps

module bls_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bls_pkg::cfg_t                        cfg,
	input  logic                                 q_valid,
	input  logic [2*COORD_BITS:0]                q_data,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [COORD_BITS-1:0]         pixel_x,
	output logic signed [COORD_BITS-1:0]         pixel_y,
	output logic                                 in_window,
	output logic [bls_pkg::ADDR_BITS-1:0]        byte_address,
	output logic                                 last
);
	import bls_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int CW = ((CB > WIN_BITS) ? CB : WIN_BITS) + 2;
	localparam int XW = BPP_BITS + WIN_BITS;

	logic [CB-1:0]        hx, hy;
	logic                 hlast;
	logic signed [CW-1:0] sx, sy, ww, wh;
	logic [WIN_BITS-1:0]  ux, uy;
	logic                 win_hit;

	logic                 vld_s1;
	logic [CB-1:0]        x_s1, y_s1;
	logic                 last_s1, inside_s1;
	logic [ADDR_BITS-1:0] ymul_s1;
	logic [XW-1:0]        xmul_s1;

	logic                 out_valid_q;
	logic                 rdy_out, rdy_s1;

	assign {hlast, hy, hx} = q_data;

	always_comb begin
		sx      = $signed({{(CW-CB){hx[CB-1]}}, hx});
		sy      = $signed({{(CW-CB){hy[CB-1]}}, hy});
		ww      = $signed({{(CW-WIN_BITS){1'b0}}, cfg.win_width});
		wh      = $signed({{(CW-WIN_BITS){1'b0}}, cfg.win_rows});
		win_hit = (sx > 0) && (sy > 0) && (sx < ww) && (sy < wh);
		// inside the window both coordinates fit the window width
		ux      = sx[WIN_BITS-1:0];
		uy      = sy[WIN_BITS-1:0];
	end

	assign rdy_out   = !out_valid_q || !out_stall;
	assign rdy_s1    = !vld_s1 || rdy_out;
	assign q_pop     = q_valid && rdy_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= q_valid;
			end
			if (rdy_out) begin
				out_valid_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_s1      <= hx;
			y_s1      <= hy;
			last_s1   <= hlast;
			inside_s1 <= win_hit;
			ymul_s1   <= {{(ADDR_BITS-WIN_BITS){1'b0}}, uy} *
			             {{(ADDR_BITS-LINE_BITS){1'b0}}, cfg.line_bytes};
			xmul_s1   <= {{BPP_BITS{1'b0}}, ux} * {{WIN_BITS{1'b0}}, cfg.bytes_per_pixel};
		end
		if (rdy_out && vld_s1) begin
			pixel_x      <= x_s1;
			pixel_y      <= y_s1;
			last         <= last_s1;
			in_window    <= inside_s1;
			// drop the address for points outside the window
			byte_address <= inside_s1 ?
			                ymul_s1 + {{(ADDR_BITS-XW){1'b0}}, xmul_s1} : '0;
		end
	end

endmodule
